// ===== rtl/core/pfp_pkg.sv =====
// Shared types, codes and constants of the per-source flood policer.
package pfp_pkg;

  localparam int unsigned WindowMs      = 1000;
  localparam int unsigned DecayPeriodMs = 60000;
  localparam int unsigned FloodPenalty  = 5;
  localparam int unsigned WarnRepeatMax = 3;
  localparam int unsigned FifoDepth     = 2;

  // Configuration register indexes
  localparam logic [2:0] CFG_WARN_LEVEL = 3'd0;
  localparam logic [2:0] CFG_KICK_LEVEL = 3'd1;
  localparam logic [2:0] CFG_BAN_LEVEL  = 3'd2;
  localparam logic [2:0] CFG_DECAY_AMT  = 3'd3;
  localparam logic [2:0] CFG_PKT_LIMIT  = 3'd4;
  localparam logic [2:0] CFG_KICK_HITS  = 3'd5;

  // Request type codes on the wire
  localparam logic [2:0] REQ_PACKET = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_EVAL   = 3'd2;
  localparam logic [2:0] REQ_DECAY  = 3'd3;
  localparam logic [2:0] REQ_ENTER  = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_WARN = 2'd1;
  localparam logic [1:0] VERDICT_KICK = 2'd2;
  localparam logic [1:0] VERDICT_BAN  = 2'd3;

  typedef enum logic [2:0] {
    OP_PACKET,
    OP_ADD,
    OP_EVAL,
    OP_DECAY,
    OP_ENTER,
    OP_READ,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DECAY,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e                op;
    logic               in_range;
    logic [7:0]         slot;
    logic signed [10:0] points;
    logic [31:0]        now_ms;
  } cmd_t;

  typedef struct packed {
    logic [14:0] warn_level;
    logic [14:0] kick_level;
    logic [14:0] ban_level;
    logic [9:0]  decay_amount;
    logic [15:0] packets_per_window;
    logic [7:0]  flood_kick_hits;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] score;
    logic [2:0]         warn;
    logic [15:0]        wcount;
    logic [31:0]        wstart;
    logic [7:0]         flood;
  } entry_t;

  typedef struct packed {
    logic [1:0] level;
  } front_sts_t;

  typedef struct packed {
    logic clearing;
    logic decaying;
  } back_sts_t;

  localparam cfg_t CfgReset = '{
    warn_level:         15'd50,
    kick_level:         15'd100,
    ban_level:          15'd200,
    decay_amount:       10'd5,
    packets_per_window: 16'd60,
    flood_kick_hits:    8'd5
  };

endpackage

// ===== rtl/core/pfp_req_if.sv =====
// Request channel: one beat carries one policer request.
interface pfp_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [7:0]         slot;
  logic signed [10:0] points;
  logic [31:0]        now_ms;

  modport source (output valid, req_type, slot, points, now_ms, input ready);
  modport sink   (input valid, req_type, slot, points, now_ms, output ready);
endinterface

// ===== rtl/core/pfp_rsp_if.sv =====
// Response channel: one beat carries the result of one request.
interface pfp_rsp_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               kick_flag;
  logic [1:0]         verdict;
  logic signed [15:0] score_value;
  logic               decay_done;

  modport source (output valid, accepted, kick_flag, verdict, score_value, decay_done,
                  input ready);
  modport sink   (input valid, accepted, kick_flag, verdict, score_value, decay_done,
                  output ready);
endinterface

// ===== rtl/core/per_source_flood_policer.sv =====
// Top level of the per-source flood policer: config registers, front and back.
//
// Requests arrive as beats on req_i (packet, add points, evaluate, decay
// tick, enter, read score) and each gives exactly one result beat on rsp_o,
// in order. The front end decodes beats into a two-deep queue, so it keeps
// taking requests while the back end works or while a result waits.
// The back end reads the slot's table entry from a memory with one read and
// one write port: the idle state reads the entry, then the execute state
// updates and writes it and loads the result register. A new request is
// taken only back in the idle state, after the last one is done. A decay
// tick that is due sweeps the whole table, one entry per cycle.
// After reset the back end runs a clearing pass over the whole table;
// requests are queued but not carried out until it ends. Config
// registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i at any
// time and are registered before they take effect.
// When the receiver stalls, the result holds in its register, the back end
// holds its next result, and the queue fills and then lowers req_i.ready.
module per_source_flood_policer import pfp_pkg::*; #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfp_req_if.sink     req_i,
  pfp_rsp_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t       cfg_q, cfg_d;
  cmd_t       head;
  logic       head_valid, pop;
  front_sts_t front_sts;
  back_sts_t  back_sts;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WARN_LEVEL: cfg_d.warn_level         = cfg_wdata_i[14:0];
        CFG_KICK_LEVEL: cfg_d.kick_level         = cfg_wdata_i[14:0];
        CFG_BAN_LEVEL:  cfg_d.ban_level          = cfg_wdata_i[14:0];
        CFG_DECAY_AMT:  cfg_d.decay_amount       = cfg_wdata_i[9:0];
        CFG_PKT_LIMIT:  cfg_d.packets_per_window = cfg_wdata_i;
        CFG_KICK_HITS:  cfg_d.flood_kick_hits    = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pfp_front #(.ENTRIES(ENTRIES)) u_front (
    .clk_i,
    .rst_ni,
    .req_i,
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .sts_o        (front_sts)
  );

  pfp_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_o,
    .sts_o        (back_sts)
  );

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_sts.level <= 2'(FifoDepth))
    else $error("request queue overfilled");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> front_sts.level == 2'(FifoDepth))
    else $error("ready low with room in queue");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_sts.clearing |-> !rsp_o.valid && !pop)
    else $error("activity during clearing pass");

  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(back_sts.clearing && back_sts.decaying))
    else $error("clear and decay at once");

endmodule

// ===== rtl/core/pfp_front.sv =====
// Front end: decodes request beats and queues them for the table sequencer.
module pfp_front import pfp_pkg::*; #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfp_req_if.sink    req_i,
  input  logic       pop_i,
  output logic       head_valid_o,
  output cmd_t       head_o,
  output front_sts_t sts_o
);

  cmd_t       fifo_q [FifoDepth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd;
  logic       push, pop;

  always_comb begin
    case (req_i.req_type)
      REQ_PACKET: cmd.op = OP_PACKET;
      REQ_ADD:    cmd.op = OP_ADD;
      REQ_EVAL:   cmd.op = OP_EVAL;
      REQ_DECAY:  cmd.op = OP_DECAY;
      REQ_ENTER:  cmd.op = OP_ENTER;
      REQ_READ:   cmd.op = OP_READ;
      default:    cmd.op = OP_NONE;
    endcase
    cmd.in_range = {24'd0, req_i.slot} < 32'(ENTRIES);
    cmd.slot     = req_i.slot;
    cmd.points   = req_i.points;
    cmd.now_ms   = req_i.now_ms;
  end

  assign req_i.ready  = cnt_q != 2'(FifoDepth);
  assign push         = req_i.valid && req_i.ready;
  assign head_valid_o = cnt_q != 2'd0;
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rp_q];
  assign sts_o.level  = cnt_q;

  always_comb begin
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = pop ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cmd;
    end
  end

endmodule

// ===== rtl/core/pfp_back.sv =====
// Back end: source table memory and the sequencer that carries out requests.
module pfp_back import pfp_pkg::*; #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      head_valid_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  pfp_rsp_if.source rsp_o,
  output back_sts_t sts_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  entry_t mem_q [ENTRIES];
  entry_t rd_q;

  state_e             state_q, state_d;
  logic [CW-1:0]      k_q, k_d;
  cmd_t               cur_q, cur_d;
  logic [31:0]        last_decay_q, last_decay_d;
  logic signed [15:0] dscore_q, dscore_d;
  logic               due_q, due_d;

  logic               out_v_q, out_v_d;
  logic               out_acc_q, out_acc_d, out_kick_q, out_kick_d, out_done_q, out_done_d;
  logic [1:0]         out_verd_q, out_verd_d;
  logic signed [15:0] out_score_q, out_score_d;

  logic               out_free, head_due;
  logic               we;
  logic [IW-1:0]      wa, ra;
  entry_t             wd;

  // Execute-stage results
  entry_t             base, nxt;
  logic               ex_we, ex_acc, ex_kick;
  logic [1:0]         ex_verd;
  logic signed [15:0] ex_score;
  logic [31:0]        age;
  logic [16:0]        cnt;
  logic signed [16:0] sum;
  logic signed [16:0] sc_x;

  // Decay-sweep entry
  entry_t             dec;
  logic signed [16:0] dv;

  assign out_free = !out_v_q || rsp_o.ready;
  assign head_due = (head_i.now_ms - last_decay_q) >= 32'(DecayPeriodMs);
  assign pop_o    = (state_q == ST_IDLE) && head_valid_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (k_q == CW'(ENTRIES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (head_valid_i) begin
          state_d = (head_i.op == OP_DECAY && head_due) ? ST_DECAY : ST_EXEC;
        end
      end
      ST_EXEC:  if (out_free) state_d = ST_IDLE;
      ST_DECAY: if (k_q == CW'(ENTRIES)) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Execute a single-entry request on the entry just read
  always_comb begin
    base = rd_q;
    if (!rd_q.valid) begin
      base       = '0;
      base.valid = 1'b1;
    end
    nxt      = rd_q;
    ex_we    = 1'b0;
    ex_acc   = 1'b0;
    ex_kick  = 1'b0;
    ex_verd  = VERDICT_NONE;
    age      = cur_q.now_ms - base.wstart;
    cnt      = {1'b0, base.wcount} + 17'd1;
    sum      = '0;
    sc_x     = {rd_q.score[15], rd_q.score};
    case (cur_q.op)
      OP_PACKET: begin
        nxt   = base;
        ex_we = 1'b1;
        if (age >= 32'(WindowMs)) begin
          nxt.wcount = 16'd1;
          nxt.wstart = cur_q.now_ms;
          ex_acc     = 1'b1;
        end else begin
          nxt.wcount = cnt[16] ? 16'hFFFF : cnt[15:0];
          if (cnt > {1'b0, cfg_i.packets_per_window}) begin
            if (base.flood != 8'hFF) nxt.flood = base.flood + 8'd1;
            sum = {base.score[15], base.score} + 17'(FloodPenalty);
            ex_kick = nxt.flood >= cfg_i.flood_kick_hits;
          end else begin
            if (base.flood != 8'd0) nxt.flood = base.flood - 8'd1;
            sum    = {base.score[15], base.score};
            ex_acc = 1'b1;
          end
          // saturate to the 16-bit score range
          if (sum > 17'sd32767)       nxt.score = 16'sh7FFF;
          else if (sum < -17'sd32768) nxt.score = -16'sh8000;
          else                        nxt.score = sum[15:0];
        end
      end
      OP_ADD: begin
        nxt   = base;
        ex_we = 1'b1;
        sum   = {base.score[15], base.score} + {{6{cur_q.points[10]}}, cur_q.points};
        if (sum > 17'sd32767)       nxt.score = 16'sh7FFF;
        else if (sum < -17'sd32768) nxt.score = -16'sh8000;
        else                        nxt.score = sum[15:0];
      end
      OP_EVAL: begin
        if (rd_q.valid) begin
          if (sc_x >= $signed({2'b00, cfg_i.ban_level})) begin
            ex_verd = VERDICT_BAN;
          end else if (sc_x >= $signed({2'b00, cfg_i.kick_level})) begin
            ex_verd = VERDICT_KICK;
          end else if (sc_x >= $signed({2'b00, cfg_i.warn_level})) begin
            ex_we = 1'b1;
            if (rd_q.warn != 3'd7) nxt.warn = rd_q.warn + 3'd1;
            if (nxt.warn <= 3'(WarnRepeatMax)) ex_verd = VERDICT_WARN;
          end
        end
      end
      OP_ENTER: begin
        nxt       = '0;
        nxt.valid = 1'b1;
        ex_we     = 1'b1;
      end
      default: ;
    endcase
    if (!cur_q.in_range) begin
      ex_we   = 1'b0;
      ex_acc  = 1'b0;
      ex_kick = 1'b0;
      ex_verd = VERDICT_NONE;
    end
    ex_score = (cur_q.in_range && cur_q.op != OP_NONE && nxt.valid) ? nxt.score : 16'sd0;
  end

  // Decay the entry read during the sweep, clamped at zero
  always_comb begin
    dec = rd_q;
    dv  = {rd_q.score[15], rd_q.score} - $signed({7'd0, cfg_i.decay_amount});
    if (rd_q.valid) dec.score = dv[16] ? 16'sd0 : dv[15:0];
  end

  // Datapath and outputs
  always_comb begin
    k_d          = k_q;
    cur_d        = cur_q;
    last_decay_d = last_decay_q;
    dscore_d     = dscore_q;
    due_d        = due_q;
    we           = 1'b0;
    wa           = IW'(k_q);
    wd           = '0;
    ra           = IW'(head_i.slot);
    out_v_d      = out_v_q && !rsp_o.ready;
    out_acc_d    = out_acc_q;
    out_kick_d   = out_kick_q;
    out_verd_d   = out_verd_q;
    out_score_d  = out_score_q;
    out_done_d   = out_done_q;
    case (state_q)
      ST_CLEAR: begin
        we  = 1'b1;
        k_d = (k_q == CW'(ENTRIES - 1)) ? '0 : k_q + CW'(1);
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          cur_d    = head_i;
          k_d      = '0;
          dscore_d = 16'sd0;
          due_d    = head_i.op == OP_DECAY && head_due;
          if (due_d) last_decay_d = head_i.now_ms;
        end
      end
      ST_EXEC: begin
        // keep the current entry in the read register while the result waits
        ra = IW'(cur_q.slot);
        if (out_free) begin
          we          = ex_we;
          wa          = IW'(cur_q.slot);
          wd          = nxt;
          out_v_d     = 1'b1;
          out_acc_d   = ex_acc;
          out_kick_d  = ex_kick;
          out_verd_d  = ex_verd;
          out_score_d = ex_score;
          out_done_d  = 1'b0;
        end
      end
      ST_DECAY: begin
        // read entry k while writing back entry k-1
        ra  = IW'(k_q);
        k_d = k_q + CW'(1);
        if (k_q != '0) begin
          we = 1'b1;
          wa = IW'(k_q - CW'(1));
          wd = dec;
          if (cur_q.in_range && wa == IW'(cur_q.slot)) begin
            dscore_d = dec.valid ? dec.score : 16'sd0;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_acc_d   = 1'b0;
          out_kick_d  = 1'b0;
          out_verd_d  = VERDICT_NONE;
          out_score_d = dscore_q;
          out_done_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      k_q          <= '0;
      last_decay_q <= '0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      last_decay_q <= last_decay_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    dscore_q    <= dscore_d;
    due_q       <= due_d;
    out_acc_q   <= out_acc_d;
    out_kick_q  <= out_kick_d;
    out_verd_q  <= out_verd_d;
    out_score_q <= out_score_d;
    out_done_q  <= out_done_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  assign rsp_o.valid       = out_v_q;
  assign rsp_o.accepted    = out_acc_q;
  assign rsp_o.kick_flag   = out_kick_q;
  assign rsp_o.verdict     = out_verd_q;
  assign rsp_o.score_value = out_score_q;
  assign rsp_o.decay_done  = out_done_q;

  assign sts_o.clearing = state_q == ST_CLEAR;
  assign sts_o.decaying = state_q == ST_DECAY;

endmodule
